// ----- sv/sprd_pkg.sv -----
package sprd_pkg;

  // Fixed field widths of the request and response beats.
  localparam int unsigned ScrBits = 12;
  localparam int unsigned DirBits = 16;

  // Register file geometry: 48-bit rows force the 64-bit, 8-byte-stride map.
  localparam int unsigned ApbAddrBits = 6;
  localparam int unsigned ApbDataBits = 64;
  localparam int unsigned RegIdxLsb   = 3;

  localparam int unsigned WidthBits = 13;
  localparam int unsigned ScaleBits = 16;
  localparam int unsigned RowBits   = 48;
  localparam int unsigned EntryBits = 16;

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_PROJ_X   = 3'd2,
    REG_PROJ_Y   = 3'd3,
    REG_ROT0     = 3'd4,
    REG_ROT1     = 3'd5,
    REG_ROT2     = 3'd6
  } reg_idx_e;

endpackage

// ----- sv/sprd_if.sv -----
interface sprd_req_if;
  logic                             valid;
  logic                             ready;
  logic [sprd_pkg::ScrBits-1:0]     screen_x;
  logic [sprd_pkg::ScrBits-1:0]     screen_y;

  modport source (output valid, screen_x, screen_y, input ready);
  modport sink   (input valid, screen_x, screen_y, output ready);
endinterface

interface sprd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [sprd_pkg::DirBits-1:0] dir_x;
  logic signed [sprd_pkg::DirBits-1:0] dir_y;
  logic signed [sprd_pkg::DirBits-1:0] dir_z;
  logic                             degenerate;

  modport source (output valid, dir_x, dir_y, dir_z, degenerate, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, degenerate, output ready);
endinterface

// ----- sv/screen_pick_ray_direction.sv -----
// Channel  | Dir | Beat contents
// ---------+-----+---------------------------------------------------
// req_i    | in  | screen_x, screen_y (pixel position)
// rsp_o    | out | dir_x, dir_y, dir_z (Q2.14 at F=14), degenerate
// APB      | in  | 7 registers, 64-bit data, byte address 8*index
//
// One beat in and one beat out per cycle, sustained while the output is not stalled.
// The pipeline depth is set by the three bit-per-stage divider pipelines and the
// 32-stage square root pipeline.
// Reset clears the valid bits of every stage and loads the register defaults.
// A stalled output freezes the whole pipeline; req_i.ready drops the same cycle.
module screen_pick_ray_direction #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sprd_req_if.sink                           req_i,
  sprd_rsp_if.source                         rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sprd_pkg::ApbAddrBits-1:0]   paddr,
  input  logic [sprd_pkg::ApbDataBits-1:0]   pwdata,
  output logic [sprd_pkg::ApbDataBits-1:0]   prdata,
  output logic                               pready
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned N1  = sprd_pkg::ScrBits + F + 1;   // ndc quotient
  localparam int unsigned N2  = N1 + 8;                      // Q8.8 scale divide
  localparam int unsigned N4  = 32 + F;                      // normalize divide
  localparam int unsigned PW  = 48;
  localparam int unsigned AW  = PW + 2;
  localparam int unsigned SqStages = 32;
  localparam int unsigned WB  = sprd_pkg::WidthBits;
  localparam int unsigned SB  = sprd_pkg::ScaleBits;
  localparam int unsigned RB  = sprd_pkg::RowBits;
  localparam int unsigned EB  = sprd_pkg::EntryBits;
  localparam int unsigned DB  = sprd_pkg::DirBits;

  localparam logic [N1-1:0]        OneN1   = N1'(64'd1 << F);
  localparam logic signed [AW-1:0] RndAdd  = AW'((64'd1 << F) - 64'd1);
  localparam logic signed [AW-1:0] Max32   = AW'(64'sh7FFF_FFFF);
  localparam logic signed [AW-1:0] Min32   = -(AW'(64'sh8000_0000));
  localparam logic [RB-1:0]        RotRst0 = RB'(64'd1 << F);
  localparam logic [RB-1:0]        RotRst1 = RB'((64'd1 << F) << 16);
  localparam logic [RB-1:0]        RotRst2 = RB'((64'd1 << F) << 32);

  // ---------------------------------------------------------------- registers
  logic [WB-1:0] scr_w_q, scr_h_q;
  logic [SB-1:0] proj_x_q, proj_y_q;
  logic [RB-1:0] rot_q [3];
  logic          cfg_wr;
  sprd_pkg::reg_idx_e cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = sprd_pkg::reg_idx_e'(paddr[sprd_pkg::ApbAddrBits-1:sprd_pkg::RegIdxLsb]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= WB'(640);
      scr_h_q  <= WB'(480);
      proj_x_q <= SB'(256);
      proj_y_q <= SB'(256);
      rot_q[0] <= RotRst0;
      rot_q[1] <= RotRst1;
      rot_q[2] <= RotRst2;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sprd_pkg::REG_SCREEN_W: scr_w_q  <= pwdata[WB-1:0];
        sprd_pkg::REG_SCREEN_H: scr_h_q  <= pwdata[WB-1:0];
        sprd_pkg::REG_PROJ_X:   proj_x_q <= pwdata[SB-1:0];
        sprd_pkg::REG_PROJ_Y:   proj_y_q <= pwdata[SB-1:0];
        sprd_pkg::REG_ROT0:     rot_q[0] <= pwdata[RB-1:0];
        sprd_pkg::REG_ROT1:     rot_q[1] <= pwdata[RB-1:0];
        sprd_pkg::REG_ROT2:     rot_q[2] <= pwdata[RB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sprd_pkg::REG_SCREEN_W: prdata = 64'(scr_w_q);
      sprd_pkg::REG_SCREEN_H: prdata = 64'(scr_h_q);
      sprd_pkg::REG_PROJ_X:   prdata = 64'(proj_x_q);
      sprd_pkg::REG_PROJ_Y:   prdata = 64'(proj_y_q);
      sprd_pkg::REG_ROT0:     prdata = 64'(rot_q[0]);
      sprd_pkg::REG_ROT1:     prdata = 64'(rot_q[1]);
      sprd_pkg::REG_ROT2:     prdata = 64'(rot_q[2]);
      default:                prdata = '0;
    endcase
  end

  // zero divisors count as one
  logic [WB-1:0] scr_w_div, scr_h_div;
  logic [SB-1:0] proj_x_div, proj_y_div;
  assign scr_w_div  = (scr_w_q == '0) ? WB'(1) : scr_w_q;
  assign scr_h_div  = (scr_h_q == '0) ? WB'(1) : scr_h_q;
  assign proj_x_div = (proj_x_q == '0) ? SB'(1) : proj_x_q;
  assign proj_y_div = (proj_y_q == '0) ? SB'(1) : proj_y_q;

  logic signed [EB-1:0] mat [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mat[r][c] = signed'(rot_q[r][EB*c +: EB]);
      end
    end
  end

  // ---------------------------------------------------------------- flow
  logic out_valid_q;
  logic adv;
  assign adv         = !out_valid_q || rsp_o.ready;
  assign req_i.ready = adv;

  // ---------------------------------------------------------------- ndc divide
  logic          d1_valid;
  logic [N1-1:0] q1x, q1y;

  sprd_pdiv #(.NumBits(N1), .DenBits(WB), .SideBits(1)) u_div_nx (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(req_i.valid),
    .num_i({req_i.screen_x, {(F + 1){1'b0}}}),
    .den_i(scr_w_div), .side_i(1'b0),
    .valid_o(d1_valid), .quo_o(q1x), .side_o()
  );

  sprd_pdiv #(.NumBits(N1), .DenBits(WB), .SideBits(1)) u_div_ny (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(req_i.valid),
    .num_i({req_i.screen_y, {(F + 1){1'b0}}}),
    .den_i(scr_h_div), .side_i(1'b0),
    .valid_o(), .quo_o(q1y), .side_o()
  );

  // nx = q - 1, ny = 1 - q, kept as sign and magnitude
  logic          nrm_valid_q;
  logic          nx_neg_q, ny_neg_q;
  logic [N1-1:0] nx_mag_q, ny_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nrm_valid_q <= 1'b0;
    else if (adv) nrm_valid_q <= d1_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_neg_q <= (q1x < OneN1);
      nx_mag_q <= (q1x < OneN1) ? (OneN1 - q1x) : (q1x - OneN1);
      ny_neg_q <= (q1y > OneN1);
      ny_mag_q <= (q1y > OneN1) ? (q1y - OneN1) : (OneN1 - q1y);
    end
  end

  // ---------------------------------------------------------------- scale divide
  logic          d2_valid;
  logic [N2-1:0] q2x, q2y;
  logic          s2x, s2y;

  sprd_pdiv #(.NumBits(N2), .DenBits(SB), .SideBits(1)) u_div_vx (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(nrm_valid_q), .num_i({nx_mag_q, 8'd0}),
    .den_i(proj_x_div), .side_i(nx_neg_q),
    .valid_o(d2_valid), .quo_o(q2x), .side_o(s2x)
  );

  sprd_pdiv #(.NumBits(N2), .DenBits(SB), .SideBits(1)) u_div_vy (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(nrm_valid_q), .num_i({ny_mag_q, 8'd0}),
    .den_i(proj_y_div), .side_i(ny_neg_q),
    .valid_o(), .quo_o(q2y), .side_o(s2y)
  );

  logic              vec_valid_q;
  logic signed [31:0] vx_q, vy_q;
  logic signed [31:0] vx_d, vy_d;
  logic [63:0]        q2x_w, q2y_w;

  always_comb begin
    q2x_w = 64'(q2x);
    q2y_w = 64'(q2y);
    if (s2x) vx_d = (q2x_w > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - q2x_w);
    else     vx_d = (q2x_w > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(q2x_w[31:0]);
    if (s2y) vy_d = (q2y_w > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - q2y_w);
    else     vy_d = (q2y_w > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(q2y_w[31:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vec_valid_q <= 1'b0;
    else if (adv) vec_valid_q <= d2_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx_q <= vx_d;
      vy_q <= vy_d;
    end
  end

  // ---------------------------------------------------------------- rotate
  logic              prd_valid_q, acc_valid_q, dir_valid_q;
  logic signed [PW-1:0] p0_q [3], p1_q [3], p2_q [3];
  logic signed [AW-1:0] acc_q [3];
  logic [95:0]          dir_q;
  logic [95:0]          dir_d;
  logic signed [AW-1:0] adj, shr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_valid_q <= 1'b0;
      acc_valid_q <= 1'b0;
      dir_valid_q <= 1'b0;
    end else if (adv) begin
      prd_valid_q <= vec_valid_q;
      acc_valid_q <= prd_valid_q;
      dir_valid_q <= acc_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        p0_q[j]  <= PW'(vx_q) * PW'(mat[0][j]);
        p1_q[j]  <= PW'(vy_q) * PW'(mat[1][j]);
        p2_q[j]  <= PW'(mat[2][j]) <<< F;
        acc_q[j] <= AW'(p0_q[j]) + AW'(p1_q[j]) + AW'(p2_q[j]);
      end
      dir_q <= dir_d;
    end
  end

  // shift down toward zero, then clamp to 32 bits
  always_comb begin
    adj   = '0;
    shr   = '0;
    dir_d = '0;
    for (int j = 0; j < 3; j++) begin
      adj = acc_q[j] + (acc_q[j][AW-1] ? RndAdd : AW'(0));
      shr = adj >>> F;
      if (shr > Max32)      dir_d[32*j +: 32] = 32'h7FFF_FFFF;
      else if (shr < Min32) dir_d[32*j +: 32] = 32'h8000_0000;
      else                  dir_d[32*j +: 32] = shr[31:0];
    end
  end

  // ---------------------------------------------------------------- squares
  logic        sq_valid_q, ss_valid_q;
  logic [63:0] sq_q [3];
  logic [95:0] dir_sq_q, dir_ss_q;
  logic [63:0] sumsq_q;
  logic [31:0] dmag [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dmag[j] = dir_q[32*j + 31] ? (32'd0 - dir_q[32*j +: 32]) : dir_q[32*j +: 32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      ss_valid_q <= 1'b0;
    end else if (adv) begin
      sq_valid_q <= dir_valid_q;
      ss_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        sq_q[j] <= 64'(dmag[j]) * 64'(dmag[j]);
      end
      dir_sq_q <= dir_q;
      sumsq_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      dir_ss_q <= dir_sq_q;
    end
  end

  // ---------------------------------------------------------------- square root
  logic        rt_valid_q [SqStages];
  logic [63:0] rt_n_q     [SqStages];
  logic [63:0] rt_res_q   [SqStages];
  logic [95:0] rt_dir_q   [SqStages];

  for (genvar k = 0; k < SqStages; k++) begin : g_rt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic        v_prev;
    logic [63:0] n_prev, r_prev, trial, n_d, r_d;
    logic [95:0] dv_prev;

    if (k == 0) begin : g_first
      assign v_prev  = ss_valid_q;
      assign n_prev  = sumsq_q;
      assign r_prev  = '0;
      assign dv_prev = dir_ss_q;
    end else begin : g_next
      assign v_prev  = rt_valid_q[k-1];
      assign n_prev  = rt_n_q[k-1];
      assign r_prev  = rt_res_q[k-1];
      assign dv_prev = rt_dir_q[k-1];
    end

    always_comb begin
      trial = r_prev + Bit;
      if (n_prev >= trial) begin
        n_d = n_prev - trial;
        r_d = (r_prev >> 1) + Bit;
      end else begin
        n_d = n_prev;
        r_d = r_prev >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rt_valid_q[k] <= 1'b0;
      else if (adv) rt_valid_q[k] <= v_prev;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_n_q[k]   <= n_d;
        rt_res_q[k] <= r_d;
        rt_dir_q[k] <= dv_prev;
      end
    end
  end

  // ---------------------------------------------------------------- normalize
  logic        lin_valid_q;
  logic        lin_degen_q;
  logic [31:0] lin_den_q;
  logic [31:0] lin_mag_q [3];
  logic [2:0]  lin_neg_q;
  logic [31:0] len;
  logic [95:0] rt_dir_last;

  assign len         = rt_res_q[SqStages-1][31:0];
  assign rt_dir_last = rt_dir_q[SqStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lin_valid_q <= 1'b0;
    else if (adv) lin_valid_q <= rt_valid_q[SqStages-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lin_degen_q <= (len == '0);
      lin_den_q   <= (len == '0) ? 32'd1 : len;
      for (int j = 0; j < 3; j++) begin
        lin_neg_q[j] <= rt_dir_last[32*j + 31];
        lin_mag_q[j] <= rt_dir_last[32*j + 31] ? (32'd0 - rt_dir_last[32*j +: 32])
                                               : rt_dir_last[32*j +: 32];
      end
    end
  end

  logic          d4_valid;
  logic [N4-1:0] q4 [3];
  logic [1:0]    s4 [3];   // {negative, degenerate}

  for (genvar j = 0; j < 3; j++) begin : g_norm
    logic v_o;
    sprd_pdiv #(.NumBits(N4), .DenBits(32), .SideBits(2)) u_div_dir (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(lin_valid_q), .num_i({lin_mag_q[j], {F{1'b0}}}),
      .den_i(lin_den_q), .side_i({lin_neg_q[j], lin_degen_q}),
      .valid_o(v_o), .quo_o(q4[j]), .side_o(s4[j])
    );
    if (j == 0) begin : g_v
      assign d4_valid = v_o;
    end
  end

  // ---------------------------------------------------------------- output
  logic signed [DB-1:0] out_dir_q [3];
  logic signed [DB-1:0] out_dir_d [3];
  logic                 out_degen_q;
  logic [63:0]          q4w;

  always_comb begin
    q4w = '0;
    for (int j = 0; j < 3; j++) begin
      q4w = 64'(q4[j]);
      if (s4[j][0])      out_dir_d[j] = '0;
      else if (s4[j][1]) out_dir_d[j] = (q4w > 64'd32768) ? 16'sh8000 : DB'(64'd0 - q4w);
      else               out_dir_d[j] = (q4w > 64'd32767) ? 16'sh7FFF : signed'(q4w[DB-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= d4_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_dir_q   <= out_dir_d;
      out_degen_q <= s4[0][0];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.dir_x      = out_dir_q[0];
  assign rsp_o.dir_y      = out_dir_q[1];
  assign rsp_o.dir_z      = out_dir_q[2];
  assign rsp_o.degenerate = out_degen_q;

  // ---------------------------------------------------------------- checks
  ap_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.degenerate |->
      rsp_o.dir_x == '0 && rsp_o.dir_y == '0 && rsp_o.dir_z == '0)
    else $error("degenerate beat with nonzero direction");

  ap_live_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.degenerate |->
      rsp_o.dir_x != '0 || rsp_o.dir_y != '0 || rsp_o.dir_z != '0)
    else $error("normalized direction collapsed to zero");

  ap_sumsq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ss_valid_q && sumsq_q == '0 |-> dir_ss_q == '0)
    else $error("zero length with nonzero rotated vector");

endmodule

// ----- sv/sprd_pdiv.sv -----
// Unsigned restoring divider, one quotient bit per stage, NumBits stages.
module sprd_pdiv #(
  parameter int unsigned NumBits  = 16,
  parameter int unsigned DenBits  = 16,
  parameter int unsigned SideBits = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [DenBits-1:0]  den_i,
  input  logic [SideBits-1:0] side_i,
  output logic                valid_o,
  output logic [NumBits-1:0]  quo_o,
  output logic [SideBits-1:0] side_o
);

  logic                valid_q [NumBits];
  logic [NumBits-1:0]  num_q   [NumBits];
  logic [DenBits-1:0]  rem_q   [NumBits];
  logic [DenBits-1:0]  den_q   [NumBits];
  logic [SideBits-1:0] side_q  [NumBits];

  for (genvar k = 0; k < NumBits; k++) begin : g_stage
    logic                v_prev;
    logic [NumBits-1:0]  n_prev;
    logic [DenBits-1:0]  r_prev;
    logic [DenBits-1:0]  d_prev;
    logic [SideBits-1:0] s_prev;
    logic [DenBits:0]    trial;
    logic [DenBits:0]    diff;
    logic [NumBits-1:0]  num_d;
    logic [DenBits-1:0]  rem_d;

    if (k == 0) begin : g_first
      assign v_prev = valid_i;
      assign n_prev = num_i;
      assign r_prev = '0;
      assign d_prev = den_i;
      assign s_prev = side_i;
    end else begin : g_next
      assign v_prev = valid_q[k-1];
      assign n_prev = num_q[k-1];
      assign r_prev = rem_q[k-1];
      assign d_prev = den_q[k-1];
      assign s_prev = side_q[k-1];
    end

    // numerator shifts out at the top while quotient bits shift in at the bottom
    always_comb begin
      trial = {r_prev, n_prev[NumBits-1]};
      diff  = trial - {1'b0, d_prev};
      if (trial >= {1'b0, d_prev}) begin
        rem_d = diff[DenBits-1:0];
        num_d = {n_prev[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial[DenBits-1:0];
        num_d = {n_prev[NumBits-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= num_d;
        rem_q[k]  <= rem_d;
        den_q[k]  <= d_prev;
        side_q[k] <= s_prev;
      end
    end
  end

  assign valid_o = valid_q[NumBits-1];
  assign quo_o   = num_q[NumBits-1];
  assign side_o  = side_q[NumBits-1];

endmodule
